// ===== design/tt_pkg.sv =====
`default_nettype none

package tt_pkg;

    // token length limit: a token is cut at MAX_TOKEN_LEN-1 bytes
    localparam int MAX_TOKEN_LEN = 256;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] TOKEN_LIMIT = LEN_W'(MAX_TOKEN_LEN - 1);

    localparam int LINE_W  = 16;
    localparam int MASK_W  = 6;
    localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(31);

    // at most three results per input word
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;

    // enable bits in special_mask
    localparam int SP_LBRACE = 0;
    localparam int SP_RBRACE = 1;
    localparam int SP_LPAREN = 2;
    localparam int SP_RPAREN = 3;
    localparam int SP_SEMI   = 4;
    localparam int SP_EQUALS = 5;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BARE   = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_DONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TOKEN_BYTE = 2'd0,
        KIND_TOKEN_END  = 2'd1,
        KIND_INPUT_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TYPE_BARE    = 2'd0,
        TYPE_QUOTED  = 2'd1,
        TYPE_SPECIAL = 2'd2
    } t_tok_type;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] token_byte;
        t_tok_type  token_type;
        logic       truncated;
        logic       use_new;     // selects the line count after this word's newline
    } t_result;

    // all results caused by one input word
    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [CNT_W-1:0]      count;
        logic [LINE_W-1:0]     line_old;
        logic [LINE_W-1:0]     line_new;
    } t_group;

    function automatic logic is_special(input logic [7:0] b, input logic [MASK_W-1:0] mask);
        logic hit;
        unique case (b)
            CH_LBRACE: hit = mask[SP_LBRACE];
            CH_RBRACE: hit = mask[SP_RBRACE];
            CH_LPAREN: hit = mask[SP_LPAREN];
            CH_RPAREN: hit = mask[SP_RPAREN];
            CH_SEMI:   hit = mask[SP_SEMI];
            CH_EQUALS: hit = mask[SP_EQUALS];
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== design/tt_lexer.sv =====
`default_nettype none

module tt_lexer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [7:0]                 i_data_byte,
    input  wire logic                       i_end_of_input,
    input  wire logic [tt_pkg::MASK_W-1:0]  i_special_mask,
    output tt_pkg::t_group                  o_group
);

    typedef struct packed {
        tt_pkg::t_mode                         mode;
        logic                                  esc;
        logic                                  skip;
        logic [tt_pkg::LEN_W-1:0]              len;
        logic                                  bumped;
        logic [tt_pkg::CNT_W-1:0]              cnt;
        tt_pkg::t_result [tt_pkg::MAX_RES-1:0] res;
    } t_step;

    function automatic t_step emit(input t_step s, input tt_pkg::t_kind k,
                                   input logic [7:0] b, input tt_pkg::t_tok_type ty,
                                   input logic tr);
        t_step o;
        o = s;
        o.res[s.cnt] = '{kind: k, token_byte: b, token_type: ty, truncated: tr,
                         use_new: s.bumped};
        o.cnt = s.cnt + tt_pkg::CNT_W'(1);
        return o;
    endfunction

    // append a token byte; the limit closes the token at once
    function automatic t_step push(input t_step s, input logic [7:0] b,
                                   input tt_pkg::t_tok_type ty);
        t_step o;
        o = emit(s, tt_pkg::KIND_TOKEN_BYTE, b, ty, 1'b0);
        o.len = o.len + tt_pkg::LEN_W'(1);
        if (o.len == tt_pkg::TOKEN_LIMIT) begin
            o = emit(o, tt_pkg::KIND_TOKEN_END, 8'h00, ty, 1'b1);
            if (ty == tt_pkg::TYPE_QUOTED) begin
                o.skip = 1'b1;
            end
            o.mode = tt_pkg::MODE_IDLE;
            o.len  = '0;
            o.esc  = 1'b0;
        end
        return o;
    endfunction

    function automatic t_step start_token(input t_step s, input logic [7:0] b,
                                          input logic [tt_pkg::MASK_W-1:0] mask);
        t_step o;
        o = s;
        if (b <= tt_pkg::CH_SPACE) begin
            if (b == tt_pkg::CH_NEWLINE) begin
                o.bumped = 1'b1;
            end
        end else if (b == tt_pkg::CH_QUOTE) begin
            o.mode = tt_pkg::MODE_QUOTED;
            o.len  = '0;
            o.esc  = 1'b0;
        end else if (tt_pkg::is_special(b, mask)) begin
            o = emit(o, tt_pkg::KIND_TOKEN_BYTE, b, tt_pkg::TYPE_SPECIAL, 1'b0);
            o = emit(o, tt_pkg::KIND_TOKEN_END, 8'h00, tt_pkg::TYPE_SPECIAL, 1'b0);
        end else begin
            o.mode = tt_pkg::MODE_BARE;
            o.len  = '0;
            o = push(o, b, tt_pkg::TYPE_BARE);
        end
        return o;
    endfunction

    tt_pkg::t_mode              r_mode;
    logic                       r_esc;
    logic                       r_skip;
    logic [tt_pkg::LEN_W-1:0]   r_len;
    logic [tt_pkg::LINE_W-1:0]  r_line;

    t_step                      w_st;
    logic                       w_eoi;
    logic                       w_ended;
    logic                       w_handled;
    logic [tt_pkg::LINE_W-1:0]  w_line_inc;

    assign w_eoi      = i_end_of_input || (i_data_byte == 8'h00);
    assign w_line_inc = (r_line == '1) ? r_line : r_line + tt_pkg::LINE_W'(1);

    // next state and results for one word
    always_comb begin
        w_ended   = 1'b0;
        w_handled = 1'b0;
        w_st = '{mode: r_mode, esc: r_esc, skip: r_skip, len: r_len, bumped: 1'b0,
                 cnt: '0, res: '0};
        if (r_mode == tt_pkg::MODE_DONE) begin
            w_st = emit(w_st, tt_pkg::KIND_INPUT_END, 8'h00, tt_pkg::TYPE_BARE, 1'b0);
        end else if (w_eoi) begin
            if (r_mode == tt_pkg::MODE_BARE) begin
                w_st = emit(w_st, tt_pkg::KIND_TOKEN_END, 8'h00, tt_pkg::TYPE_BARE, 1'b0);
            end else if (r_mode == tt_pkg::MODE_QUOTED) begin
                if (r_esc) begin
                    w_st    = push(w_st, tt_pkg::CH_BSLASH, tt_pkg::TYPE_QUOTED);
                    w_ended = (w_st.mode == tt_pkg::MODE_IDLE);
                end
                if (!w_ended) begin
                    w_st = emit(w_st, tt_pkg::KIND_TOKEN_END, 8'h00,
                                tt_pkg::TYPE_QUOTED, 1'b0);
                end
            end
            w_st = emit(w_st, tt_pkg::KIND_INPUT_END, 8'h00, tt_pkg::TYPE_BARE, 1'b0);
            w_st.mode = tt_pkg::MODE_DONE;
            w_st.esc  = 1'b0;
            w_st.skip = 1'b0;
            w_st.len  = '0;
        end else if (r_skip) begin
            w_st.skip = 1'b0;
        end else begin
            unique case (r_mode)
                tt_pkg::MODE_IDLE: begin
                    w_st = start_token(w_st, i_data_byte, i_special_mask);
                end
                tt_pkg::MODE_BARE: begin
                    if (i_data_byte <= tt_pkg::CH_SPACE ||
                        tt_pkg::is_special(i_data_byte, i_special_mask)) begin
                        w_st = emit(w_st, tt_pkg::KIND_TOKEN_END, 8'h00,
                                    tt_pkg::TYPE_BARE, 1'b0);
                        w_st.mode = tt_pkg::MODE_IDLE;
                        w_st.len  = '0;
                        w_st = start_token(w_st, i_data_byte, i_special_mask);
                    end else begin
                        w_st = push(w_st, i_data_byte, tt_pkg::TYPE_BARE);
                    end
                end
                tt_pkg::MODE_QUOTED: begin
                    if (r_esc) begin
                        w_st.esc = 1'b0;
                        if (i_data_byte == tt_pkg::CH_QUOTE ||
                            i_data_byte == tt_pkg::CH_BSLASH) begin
                            w_st      = push(w_st, i_data_byte, tt_pkg::TYPE_QUOTED);
                            w_handled = 1'b1;
                        end else begin
                            // keep the backslash; if that hits the limit this byte is dropped
                            w_st      = push(w_st, tt_pkg::CH_BSLASH, tt_pkg::TYPE_QUOTED);
                            w_handled = (w_st.mode == tt_pkg::MODE_IDLE);
                        end
                    end
                    if (!w_handled) begin
                        if (i_data_byte == tt_pkg::CH_QUOTE) begin
                            w_st = emit(w_st, tt_pkg::KIND_TOKEN_END, 8'h00,
                                        tt_pkg::TYPE_QUOTED, 1'b0);
                            w_st.mode = tt_pkg::MODE_IDLE;
                            w_st.len  = '0;
                        end else if (i_data_byte == tt_pkg::CH_BSLASH) begin
                            w_st.esc = 1'b1;
                        end else begin
                            if (i_data_byte == tt_pkg::CH_NEWLINE) begin
                                w_st.bumped = 1'b1;
                            end
                            w_st = push(w_st, i_data_byte, tt_pkg::TYPE_QUOTED);
                        end
                    end
                end
                default: begin
                    w_st.mode = r_mode;
                end
            endcase
        end
    end

    always_comb begin
        o_group.res      = w_st.res;
        o_group.count    = w_st.cnt;
        o_group.line_old = r_line;
        o_group.line_new = w_line_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tt_pkg::MODE_IDLE;
            r_esc  <= 1'b0;
            r_skip <= 1'b0;
            r_len  <= '0;
            r_line <= tt_pkg::LINE_W'(1);
        end else if (i_step) begin
            r_mode <= w_st.mode;
            r_esc  <= w_st.esc;
            r_skip <= w_st.skip;
            r_len  <= w_st.len;
            if (w_st.bumped) begin
                r_line <= w_line_inc;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/text_tokenizer.sv =====
// Streaming tokenizer with quoted strings.
// Input channel (i_valid / o_stall): one text byte per word, or an end-of-input
// flag. A word is taken at a clock edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): one result per word: a token byte, an
// end-of-token marker or the end-of-input marker, with o_last on the final
// result that an input word caused. A word is taken when o_valid is high and
// i_stall is low.
// Configuration (i_cfg_valid / o_cfg_ready): writes special_mask; always ready.
// The results of an input word are registered in the result-group queue before they
// are offered. Throughput: one input word per cycle while each word yields at most
// one result and the receiver does not stall; a word that yields several results
// occupies the output until each of them is taken, a word that yields none takes
// no queue entry. The rate is set by the one result per cycle that the output port
// can deliver; a two-entry result-group queue lets the next input word enter while a result still waits.
// Reset (synchronous, active low): between tokens, line count 1, special_mask
// 31, queue empty. When the receiver stalls, the offered result holds still,
// the queue fills and o_stall rises.
`default_nettype none

module text_tokenizer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [7:0]                 i_data_byte,
    input  wire logic                       i_end_of_input,
    // configuration
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tt_pkg::MASK_W-1:0]  i_cfg_special_mask,
    // output channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_token_byte,
    output logic [1:0]                      o_token_type,
    output logic                            o_truncated,
    output logic [tt_pkg::LINE_W-1:0]       o_line_number,
    output logic                            o_last
);

    logic [tt_pkg::MASK_W-1:0]  r_mask;

    // result-group queue: two entries, one group per input word that yields results
    tt_pkg::t_group             r_q [2];
    logic                       r_wr_ptr;
    logic                       r_rd_ptr;
    logic [1:0]                 r_count;
    logic [1:0]                 n_count;
    logic [tt_pkg::CNT_W-1:0]   r_sub;     // result index within head group

    tt_pkg::t_group             w_group;
    tt_pkg::t_group             w_head;
    tt_pkg::t_result            w_res;
    logic                       w_in_accept;
    logic                       w_push;
    logic                       w_out_accept;
    logic                       w_head_last;
    logic                       w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= tt_pkg::MASK_RESET;
        end else if (i_cfg_valid) begin
            r_mask <= i_cfg_special_mask;
        end
    end

    assign o_stall     = (r_count == 2'd2);
    assign w_in_accept = i_valid && !o_stall;
    // words that cause no result leave no trace in the queue
    assign w_push      = w_in_accept && (w_group.count != '0);

    tt_lexer u_lexer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_in_accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_special_mask (r_mask),
        .o_group        (w_group)
    );

    assign w_head       = r_q[r_rd_ptr];
    assign w_res        = w_head.res[r_sub];
    assign o_valid      = (r_count != 2'd0);
    assign w_head_last  = (r_sub == w_head.count - tt_pkg::CNT_W'(1));
    assign w_out_accept = o_valid && !i_stall;
    assign w_pop        = w_out_accept && w_head_last;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_out_accept) begin
                r_sub <= w_pop ? '0 : r_sub + tt_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_group;
        end
    end

    assign o_kind        = w_res.kind;
    assign o_token_byte  = w_res.token_byte;
    assign o_token_type  = w_res.token_type;
    assign o_truncated   = w_res.truncated;
    assign o_line_number = w_res.use_new ? w_head.line_new : w_head.line_old;
    assign o_last        = w_head_last;

endmodule

`default_nettype wire
